>>> src/vdifpp_pkg.sv
package vdifpp_pkg;

	// field and register widths
	localparam int FRAME_W  = 24;
	localparam int THREAD_W = 10;
	localparam int FPP_W    = 16;
	localparam int TPB_W    = 27;
	localparam int ADDR_W   = 40;
	localparam int HDR_W    = 15;
	localparam int CFG_W    = 27;
	localparam int CFG_IDX_W = 1;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_FRAMES_PER_PAGE   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_THREAD_PAGE_BYTES = 1'd1;

	// configuration reset values
	localparam logic [FPP_W-1:0] FPP_RESET = 16'd1;
	localparam logic [TPB_W-1:0] TPB_RESET = 27'd1280;

	// divider: one quotient bit per cycle
	localparam int DIV_STEPS = FRAME_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);
	localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_MUL,
		ST_COMMIT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic div_step;
		logic mul;
		logic commit;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic div_last;
		logic out_free;
	} dp_status_t;

endpackage

>>> src/vdif_frame_page_placement_core.sv
// channel   direction  handshake            beat
// in        input      in_valid/in_stall    frame_number, thread_field
// out       output     out_valid/out_stall  payload_address, header_address,
//                                           page_bit, page_flip, thread_invalid
// cfg       input      cfg_we               cfg_index, cfg_data
//
// one frame header at a time: accept, a divider step per frame-number bit, product, commit
// the throughput is set by the bit-serial divider, one quotient bit per cycle
// a stalled result holds the commit step; the input stays stalled meanwhile
// arst_n clears the controller, the page memory and the result valid
// configuration resets to one frame per page and 1280 bytes per thread page
module vdif_frame_page_placement_core #(
	parameter int THREAD_COUNT  = 4,
	parameter int PAYLOAD_BYTES = 1280,
	parameter int HEADER_BYTES  = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [vdifpp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [vdifpp_pkg::CFG_W-1:0]      cfg_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [vdifpp_pkg::FRAME_W-1:0]    frame_number,
	input  logic [vdifpp_pkg::THREAD_W-1:0]   thread_field,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [vdifpp_pkg::ADDR_W-1:0]     payload_address,
	output logic [vdifpp_pkg::HDR_W-1:0]      header_address,
	output logic                              page_bit,
	output logic                              page_flip,
	output logic                              thread_invalid
);

	vdifpp_pkg::dp_cmd_t    cmd;
	vdifpp_pkg::dp_status_t status;

	// sequencer
	vdifpp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	// divider, address arithmetic and result register
	vdifpp_datapath #(
		.THREAD_COUNT  (THREAD_COUNT),
		.PAYLOAD_BYTES (PAYLOAD_BYTES),
		.HEADER_BYTES  (HEADER_BYTES)
	) u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.status          (status),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.frame_number    (frame_number),
		.thread_field    (thread_field),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.payload_address (payload_address),
		.header_address  (header_address),
		.page_bit        (page_bit),
		.page_flip       (page_flip),
		.thread_invalid  (thread_invalid)
	);

	// an accepted beat keeps the input side busy for the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken again straight after a beat");

	// a dropped frame never flips the page
	a_no_flip_when_invalid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(page_flip && thread_invalid))
		else $error("page flip on an invalid thread");

	// a dropped frame carries zero addresses
	a_zero_addr_when_invalid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && thread_invalid |-> payload_address == '0 && header_address == '0)
		else $error("non-zero address on an invalid thread");

	// a commit only happens with room in the result register
	a_commit_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> (!out_valid || !out_stall))
		else $error("result overwritten while stalled");

endmodule

>>> src/vdifpp_ctrl.sv
module vdifpp_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  vdifpp_pkg::dp_status_t status,
	output vdifpp_pkg::dp_cmd_t    cmd
);

	vdifpp_pkg::state_t state_q;
	vdifpp_pkg::state_t state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= vdifpp_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d      = state_q;
		cmd          = '0;
		in_stall     = 1'b1;
		unique case (state_q)
			vdifpp_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = vdifpp_pkg::ST_DIV;
				end
			end
			vdifpp_pkg::ST_DIV: begin
				cmd.div_step = 1'b1;
				if (status.div_last) begin
					state_d = vdifpp_pkg::ST_MUL;
				end
			end
			vdifpp_pkg::ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = vdifpp_pkg::ST_COMMIT;
			end
			vdifpp_pkg::ST_COMMIT: begin
				// hold until the result register can take the beat
				if (status.out_free) begin
					cmd.commit = 1'b1;
					state_d    = vdifpp_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = vdifpp_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

>>> src/vdifpp_datapath.sv
module vdifpp_datapath #(
	parameter int THREAD_COUNT  = 4,
	parameter int PAYLOAD_BYTES = 1280,
	parameter int HEADER_BYTES  = 32
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  vdifpp_pkg::dp_cmd_t                   cmd,
	output vdifpp_pkg::dp_status_t                status,
	input  logic                                  cfg_we,
	input  logic [vdifpp_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [vdifpp_pkg::CFG_W-1:0]          cfg_data,
	input  logic [vdifpp_pkg::FRAME_W-1:0]        frame_number,
	input  logic [vdifpp_pkg::THREAD_W-1:0]       thread_field,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic [vdifpp_pkg::ADDR_W-1:0]         payload_address,
	output logic [vdifpp_pkg::HDR_W-1:0]          header_address,
	output logic                                  page_bit,
	output logic                                  page_flip,
	output logic                                  thread_invalid
);

	localparam int FPP_W   = vdifpp_pkg::FPP_W;
	localparam int TPB_W   = vdifpp_pkg::TPB_W;
	localparam int IDX_W   = $clog2(2 * THREAD_COUNT);
	localparam int PB_W    = $clog2(PAYLOAD_BYTES + 1);
	localparam int PPROD_W = IDX_W + TPB_W;
	localparam int SPROD_W = FPP_W + PB_W;

	logic [FPP_W-1:0]                     fpp_q;
	logic [TPB_W-1:0]                     tpb_q;
	logic [vdifpp_pkg::FRAME_W-1:0]       dividend_q;
	logic [FPP_W-1:0]                     rem_q;
	logic [vdifpp_pkg::DIV_CNT_W-1:0]     cnt_q;
	logic                                 qlsb_q;
	logic [vdifpp_pkg::THREAD_W-1:0]      field_q;
	logic [PPROD_W-1:0]                   pprod_s1;
	logic [SPROD_W-1:0]                   sprod_s1;
	logic [vdifpp_pkg::HDR_W-1:0]         hdr_s1;
	logic                                 invalid_s1;
	logic                                 last_page_q;
	logic                                 primed_q;
	logic                                 out_valid_q;
	logic [vdifpp_pkg::ADDR_W-1:0]        payload_q;
	logic [vdifpp_pkg::HDR_W-1:0]         header_q;
	logic                                 page_q;
	logic                                 flip_q;
	logic                                 invalid_q;

	logic [FPP_W-1:0]                     divisor;
	logic [FPP_W:0]                       rem_shift;
	logic                                 rem_ge;
	logic [FPP_W:0]                       rem_sub;
	logic [vdifpp_pkg::THREAD_W-1:0]      thread_idx;
	logic [IDX_W-1:0]                     row_idx;
	logic                                 invalid_c;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fpp_q <= vdifpp_pkg::FPP_RESET;
			tpb_q <= vdifpp_pkg::TPB_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				vdifpp_pkg::CFG_FRAMES_PER_PAGE:   fpp_q <= cfg_data[FPP_W-1:0];
				vdifpp_pkg::CFG_THREAD_PAGE_BYTES: tpb_q <= cfg_data[TPB_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// restoring divider step, a zero divisor counts as one
	assign divisor   = (fpp_q == '0) ? FPP_W'(1) : fpp_q;
	assign rem_shift = {rem_q, dividend_q[vdifpp_pkg::FRAME_W-1]};
	assign rem_ge    = rem_shift >= {1'b0, divisor};
	assign rem_sub   = rem_shift - {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.load) begin
			cnt_q <= '0;
		end else if (cmd.div_step) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			dividend_q <= frame_number;
			field_q    <= thread_field;
			rem_q      <= '0;
		end else if (cmd.div_step) begin
			dividend_q <= {dividend_q[vdifpp_pkg::FRAME_W-2:0], 1'b0};
			rem_q      <= rem_ge ? rem_sub[FPP_W-1:0] : rem_shift[FPP_W-1:0];
			qlsb_q     <= rem_ge;
		end
	end

	assign status.div_last = cnt_q == vdifpp_pkg::DIV_LAST;

	// thread index and row in the two-page store
	assign thread_idx = field_q - 1'b1;
	assign invalid_c  = (field_q == '0) ||
		({1'b0, field_q} > (vdifpp_pkg::THREAD_W + 1)'(THREAD_COUNT));
	assign row_idx    = IDX_W'(thread_idx) + (qlsb_q ? IDX_W'(THREAD_COUNT) : '0);

	// product stage
	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			pprod_s1   <= PPROD_W'(row_idx) * PPROD_W'(tpb_q);
			sprod_s1   <= SPROD_W'(rem_q) * SPROD_W'(PAYLOAD_BYTES);
			hdr_s1     <= vdifpp_pkg::HDR_W'(thread_idx)
				* vdifpp_pkg::HDR_W'(HEADER_BYTES);
			invalid_s1 <= invalid_c;
		end
	end

	// page memory, left alone by a dropped frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_page_q <= 1'b0;
			primed_q    <= 1'b0;
		end else if (cmd.commit && !invalid_s1) begin
			last_page_q <= qlsb_q;
			primed_q    <= 1'b1;
		end
	end

	// result register
	assign status.out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			payload_q <= invalid_s1 ? '0 :
				vdifpp_pkg::ADDR_W'(pprod_s1) + vdifpp_pkg::ADDR_W'(sprod_s1);
			header_q  <= invalid_s1 ? '0 : hdr_s1;
			page_q    <= qlsb_q;
			flip_q    <= !invalid_s1 && primed_q && (qlsb_q != last_page_q);
			invalid_q <= invalid_s1;
		end
	end

	assign out_valid       = out_valid_q;
	assign payload_address = payload_q;
	assign header_address  = header_q;
	assign page_bit        = page_q;
	assign page_flip       = flip_q;
	assign thread_invalid  = invalid_q;

endmodule
